### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, reset masked.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: ante implies cons");

// Next-cycle implication, reset masked.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: ante implies cons next cycle");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/tlvi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlvi_pkg
// Shared constants and types of the TLV insert locator.
// ----------------------------------------------------------------------------
package tlvi_pkg;

    localparam int MAX_AREA_BYTES_DEF = 4096;
    localparam int OFFS_W_DEF         = $clog2(MAX_AREA_BYTES_DEF + 1);
    localparam int BYTE_W             = 8;

    // element walk phase codes
    localparam logic [1:0] PHASE_ID   = 2'd0;
    localparam logic [1:0] PHASE_LEN  = 2'd1;
    localparam logic [1:0] PHASE_BODY = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } t_item;

endpackage

### rtl/tlvi_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlvi_if
// Valid/ready channels: byte input, config write, result output.
// ----------------------------------------------------------------------------
interface tlvi_byte_if;
    logic                          valid;
    logic                          ready;
    logic [tlvi_pkg::BYTE_W-1:0]   data_byte;
    logic                          last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tlvi_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [tlvi_pkg::BYTE_W-1:0]   insert_tag_id;

    modport source (output valid, output insert_tag_id, input ready);
    modport sink   (input valid, input insert_tag_id, output ready);
endinterface

interface tlvi_result_if #(
    parameter int OFFS_W = tlvi_pkg::OFFS_W_DEF
);
    logic              valid;
    logic              ready;
    logic [OFFS_W-1:0] insert_offset;
    logic              too_long;

    modport source (output valid, output insert_offset, output too_long, input ready);
    modport sink   (input valid, input insert_offset, input too_long, output ready);
endinterface

### rtl/tlvi_walk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlvi_walk
// TLV element walker: tracks phase, position and best lower-id offset.
// ----------------------------------------------------------------------------
module tlvi_walk #(
    parameter int MAX_AREA_BYTES = tlvi_pkg::MAX_AREA_BYTES_DEF,
    parameter int POS_W          = $clog2(MAX_AREA_BYTES + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  tlvi_pkg::t_item             i_item,
    input  logic [tlvi_pkg::BYTE_W-1:0] i_insert_tag_id,
    output logic [POS_W-1:0]            o_offset,
    output logic                        o_too_long
);

    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_AREA_BYTES);

    logic [1:0]                  r_phase,     n_phase;
    logic [tlvi_pkg::BYTE_W-1:0] r_elem_id,   n_elem_id;
    logic [tlvi_pkg::BYTE_W-1:0] r_body_left, n_body_left;
    logic [POS_W-1:0]            r_pos,       n_pos;
    logic                        r_best_none, n_best_none;
    logic [tlvi_pkg::BYTE_W-1:0] r_best_id,   n_best_id;
    logic [POS_W-1:0]            r_best_offs, n_best_offs;
    logic                        r_ovf,       n_ovf;
    logic                        done;
    logic                        qualify;

    always_comb begin
        n_ovf       = r_ovf | (r_pos == MAX_POS);
        n_pos       = (r_pos == MAX_POS) ? r_pos : r_pos + POS_W'(1);
        n_phase     = r_phase;
        n_elem_id   = r_elem_id;
        n_body_left = r_body_left;
        done        = 1'b0;

        unique case (r_phase)
            tlvi_pkg::PHASE_ID: begin
                n_elem_id = i_item.data_byte;
                n_phase   = tlvi_pkg::PHASE_LEN;
            end
            tlvi_pkg::PHASE_LEN: begin
                n_body_left = i_item.data_byte;
                if (i_item.data_byte == '0) begin
                    done    = 1'b1;
                    n_phase = tlvi_pkg::PHASE_ID;
                end else begin
                    n_phase = tlvi_pkg::PHASE_BODY;
                end
            end
            default: begin
                if (r_body_left != '0) begin
                    n_body_left = r_body_left - 8'd1;
                end
                if (n_body_left == '0) begin
                    done    = 1'b1;
                    n_phase = tlvi_pkg::PHASE_ID;
                end
            end
        endcase

        // element id is already held when the element completes
        qualify = done && !n_ovf && (r_elem_id < i_insert_tag_id)
                  && (r_best_none || (r_elem_id > r_best_id));

        n_best_none = qualify ? 1'b0      : r_best_none;
        n_best_id   = qualify ? r_elem_id : r_best_id;
        n_best_offs = qualify ? n_pos     : r_best_offs;

        o_offset    = n_best_offs;
        o_too_long  = n_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_item.last_byte)) begin
            r_phase     <= tlvi_pkg::PHASE_ID;
            r_elem_id   <= '0;
            r_body_left <= '0;
            r_pos       <= '0;
            r_best_none <= 1'b1;
            r_best_id   <= '0;
            r_best_offs <= '0;
            r_ovf       <= 1'b0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_elem_id   <= n_elem_id;
            r_body_left <= n_body_left;
            r_pos       <= n_pos;
            r_best_none <= n_best_none;
            r_best_id   <= n_best_id;
            r_best_offs <= n_best_offs;
            r_ovf       <= n_ovf;
        end
    end

endmodule

### rtl/tlv_tag_insert_locator_core.sv
`timescale 1ns / 1ps
// Path: the last byte passes the input register, then the result register,
//   before its result is offered.
// Throughput: one byte per cycle; only a last byte waits, and only while
//   the previous result still sits unclaimed in the result register.
// Reset: i_rst_n low at a clock edge clears the walk, the valid flags of
//   the input and result registers, and insert_tag_id (to 0).
// ----------------------------------------------------------------------------
// tlv_tag_insert_locator_core
// Walks TLV elements of a management frame tagged area and reports the byte
// offset just past the highest-id element below insert_tag_id.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tlv_tag_insert_locator_core #(
    parameter int MAX_AREA_BYTES = tlvi_pkg::MAX_AREA_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tlvi_byte_if.sink     i_byte,
    tlvi_cfg_if.sink      i_cfg,
    tlvi_result_if.source o_result
);

    // offset ranges 0..MAX_AREA_BYTES inclusive
    localparam int               POS_W   = $clog2(MAX_AREA_BYTES + 1);
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_AREA_BYTES);

    // config register: the user must write it only while idle (not enforced here), so no hazard with the walk
    logic [tlvi_pkg::BYTE_W-1:0] r_insert_tag_id;

    // input register stage
    logic            r_s1_valid;
    tlvi_pkg::t_item r_s1;

    // result register
    logic             r_out_valid;
    logic [POS_W-1:0] r_out_offset;
    logic             r_out_too_long;

    logic             out_free;
    logic             s1_go;
    logic [POS_W-1:0] walk_offset;
    logic             walk_too_long;

    // A non-last byte never produces a result, so it always moves on;
    // a last byte needs the result register free (or being drained).
    assign out_free     = !r_out_valid || o_result.ready;
    assign s1_go        = r_s1_valid && (!r_s1.last_byte || out_free);
    assign i_byte.ready = !r_s1_valid || s1_go;
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_insert_tag_id <= '0;
        end else if (i_cfg.valid) begin
            r_insert_tag_id <= i_cfg.insert_tag_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_s1_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.ready && i_byte.valid) begin
            r_s1.data_byte <= i_byte.data_byte;
            r_s1.last_byte <= i_byte.last_byte;
        end
    end

    tlvi_walk #(
        .MAX_AREA_BYTES (MAX_AREA_BYTES),
        .POS_W          (POS_W)
    ) u_walk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (s1_go),
        .i_item          (r_s1),
        .i_insert_tag_id (r_insert_tag_id),
        .o_offset        (walk_offset),
        .o_too_long      (walk_too_long)
    );

    // result register: loads on the last byte of an area
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_s1.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1.last_byte) begin
            r_out_offset   <= walk_offset;
            r_out_too_long <= walk_too_long;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.insert_offset = r_out_offset;
    assign o_result.too_long      = r_out_too_long;

    // a new result only follows a last byte leaving the input stage
    `ASSERT_IMPLIES(a_rise_from_last, i_clk, i_rst_n, $rose(r_out_valid), $past(s1_go && r_s1.last_byte))
    // a held result is never dropped before transfer
    `ASSERT_NEXT(a_stall_keeps, i_clk, i_rst_n, r_out_valid && !o_result.ready, r_out_valid)
    // offset never passes the saturation point
    `ASSERT_IMPLIES(a_offset_range, i_clk, i_rst_n, r_out_valid, r_out_offset <= MAX_POS)

endmodule

### dv/tlv_tag_insert_locator_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlv_tag_insert_locator_core_checker
// Monitors the byte, config and result channels, predicts the insert
// location of every area and compares it with what the core reports.
// ----------------------------------------------------------------------------
module tlv_tag_insert_locator_core_checker (
    input  logic   i_clk,
    input  logic   i_rst_n,
    tlvi_byte_if   i_byte,
    tlvi_cfg_if    i_cfg,
    tlvi_result_if i_result,
    output int     o_fail_count,
    output int     o_pending
);
    import tlvi_pkg::*;

    localparam int         AREA_MAX = MAX_AREA_BYTES_DEF;
    localparam logic [8:0] NO_LOWER = 9'h100;   // bit 8: no lower id seen yet

    typedef struct packed {
        logic [OFFS_W_DEF-1:0] insert_offset;
        logic                  too_long;
    } t_location;

    t_location             location_q[$];
    logic [7:0]            tag_id;
    logic [1:0]            phase;
    logic [7:0]            elem_id;
    logic [7:0]            body_left;
    logic [OFFS_W_DEF-1:0] area_pos;
    logic [8:0]            best_id;
    logic [OFFS_W_DEF-1:0] best_offset;
    logic                  overran;
    int                    fail_count = 0;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        fail_count++;
    endtask

    function void restart_walk();
        phase       = PHASE_ID;
        elem_id     = 8'd0;
        body_left   = 8'd0;
        area_pos    = '0;
        best_id     = NO_LOWER;
        best_offset = '0;
        overran     = 1'b0;
    endfunction

    // completed element: keep it if it is the highest id below the tag so far
    function void close_element();
        if (!overran && elem_id < tag_id && (best_id[8] || elem_id > best_id[7:0])) begin
            best_id     = {1'b0, elem_id};
            best_offset = area_pos;
        end
    endfunction

    function void take_byte(input logic [7:0] b, input logic last);
        t_location loc;
        if (area_pos >= AREA_MAX)
            overran = 1'b1;
        else
            area_pos = area_pos + 1'b1;
        case (phase)
            PHASE_ID: begin
                elem_id = b;
                phase   = PHASE_LEN;
            end
            PHASE_LEN: begin
                body_left = b;
                if (b == 8'd0) begin
                    close_element();
                    phase = PHASE_ID;
                end else begin
                    phase = PHASE_BODY;
                end
            end
            default: begin
                if (body_left != 8'd0)
                    body_left = body_left - 1'b1;
                if (body_left == 8'd0) begin
                    close_element();
                    phase = PHASE_ID;
                end
            end
        endcase
        if (last) begin
            loc.insert_offset = best_offset;
            loc.too_long      = overran;
            location_q.push_back(loc);
            restart_walk();
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_location want;
        if (!i_rst_n) begin
            tag_id = 8'd0;
            restart_walk();
            location_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready)
                tag_id = i_cfg.insert_tag_id;
            if (i_result.valid && i_result.ready) begin
                if (location_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result offset %0d too_long %0b",
                                              i_result.insert_offset, i_result.too_long));
                end else begin
                    want = location_q.pop_front();
                    if (i_result.insert_offset !== want.insert_offset)
                        report_mismatch($sformatf("insert_offset %0d, want %0d",
                                                  i_result.insert_offset, want.insert_offset));
                    if (i_result.too_long !== want.too_long)
                        report_mismatch($sformatf("too_long %0b, want %0b",
                                                  i_result.too_long, want.too_long));
                end
            end
            if (i_byte.valid && i_byte.ready)
                take_byte(i_byte.data_byte, i_byte.last_byte);
        end
        o_fail_count <= fail_count;
        o_pending    <= location_q.size();
    end

endmodule

### dv/tlv_tag_insert_locator_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlv_tag_insert_locator_core_test
// Drives tagged-parameter areas byte by byte into the core: a short directed
// set, then random walks, truncated walks and noise, under several insert
// tag settings. A checker beside the core predicts every result; this module
// gives the verdict.
// ----------------------------------------------------------------------------
module tlv_tag_insert_locator_core_test;
    import tlvi_pkg::*;

    localparam int SHORT_ITEMS   = 1450;  // bytes in the random short areas
    localparam int IDLE_LIMIT    = 2000;  // cycles without any transfer
    localparam int SETTLE_CYCLES = 8;     // margin after the last result is taken
    localparam int PHASE_AREAS   = 20;    // areas between setting changes

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    int         fail_count;
    int         pending;
    int         res_hold    = 0;
    int         idle_cycles = 0;
    bit         steady      = 1'b0;   // while set, neither side idles
    logic [7:0] cur_tag     = 8'd0;   // mirror of the last tag written
    logic [7:0] area_bytes[$];        // area under construction

    always #5 i_clk = ~i_clk;

    tlvi_byte_if   byte_if ();
    tlvi_cfg_if    cfg_if ();
    tlvi_result_if res_if ();

    tlv_tag_insert_locator_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (byte_if),
        .i_cfg    (cfg_if),
        .o_result (res_if)
    );

    tlv_tag_insert_locator_core_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte       (byte_if),
        .i_cfg        (cfg_if),
        .i_result     (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Ids cluster around the tag so that the "highest below" race is busy,
    // with the extremes thrown in often.
    function automatic logic [7:0] pick_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return cur_tag + 8'($urandom_range(0, 3)) - 8'd2;
        if (r < 50)
            return 8'd0;
        if (r < 60)
            return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    // Fill area_bytes with complete elements totalling exactly total bytes (a total of one gives a lone id).
    // With final_best set and a nonzero tag, only the closing element qualifies (id tag-1),
    // so the reported offset is the end of the area.
    function automatic void build_walk(input int total, input int max_len,
                                       input bit final_best);
        int         rem;
        int         len;
        logic [7:0] id;
        area_bytes.delete();
        rem = total;
        while (rem > 0) begin
            if (rem == 1) begin
                // single-byte area: a lone id, never completed
                area_bytes.push_back(pick_id());
                rem = 0;
            end else begin
                len = $urandom_range(0, (rem - 2 < max_len) ? rem - 2 : max_len);
                // never strand a single byte at the end
                if (rem - 2 - len == 1)
                    len = (len > 0) ? len - 1 : len + 1;
                rem = rem - 2 - len;
                if (!final_best)
                    id = pick_id();
                else if (rem == 0)
                    id = cur_tag - 8'd1;
                else
                    id = 8'($urandom_range(cur_tag, 255));
                area_bytes.push_back(id);
                area_bytes.push_back(8'(len));
                repeat (len) area_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
    endfunction

    // One byte transfer. Valid stays high on exit so that a back-to-back
    // byte keeps it up; any gap lowers it first.
    task automatic send_byte(input logic [7:0] data, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            byte_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        byte_if.valid     <= 1'b1;
        byte_if.data_byte <= data;
        byte_if.last_byte <= last;
        do @(posedge i_clk); while (!byte_if.ready);
        @(negedge i_clk);
    endtask

    task automatic send_area();
        int n;
        n = area_bytes.size();
        for (int i = 0; i < n; i++)
            send_byte(area_bytes[i], i == n - 1);
    endtask

    // Hold off the sender until every predicted result has been taken.
    task automatic drain_results();
        byte_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Tag writes only on an idle core.
    task automatic write_tag(input logic [7:0] value);
        drain_results();
        cfg_if.valid         <= 1'b1;
        cfg_if.insert_tag_id <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
        cur_tag = value;
    endtask

    // Result side: ready for one cycle, then a random stall.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (res_hold > 0) begin
            res_if.ready <= 1'b0;
            res_hold     <= res_hold - 1;
        end else begin
            res_if.ready <= 1'b1;
            res_hold     <= pick_gap();
        end
    end

    // Watchdog on transfers of any kind.
    always @(posedge i_clk) begin
        if (!i_rst_n || (byte_if.valid && byte_if.ready) || (cfg_if.valid && cfg_if.ready)
            || (res_if.valid && res_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tlv_tag_insert_locator_core regression: fail");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int short_items;
        int area_count;
        int kind;
        int drop;
        byte_if.valid        = 1'b0;
        byte_if.data_byte    = 8'd0;
        byte_if.last_byte    = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.insert_tag_id = 8'd0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // ---- directed ----
        // tag still at reset value: nothing lies below zero
        area_bytes = {8'd0, 8'd0};
        send_area();
        write_tag(8'd255);
        // id zero, zero length, closing the area: offset 2
        area_bytes = {8'd0, 8'd0};
        send_area();
        // 254 qualifies at 3, the lower 3 does not replace it, 255 is not below
        area_bytes = {8'd254, 8'd1, 8'hAA, 8'd3, 8'd0, 8'd255, 8'd2, 8'h00, 8'hFF};
        send_area();
        // incomplete final element is dropped
        area_bytes = {8'd10, 8'd3, 8'h55, 8'h01};
        send_area();
        // lone id byte as the whole area
        area_bytes = {8'h80};
        send_area();
        write_tag(8'd0);
        area_bytes = {8'd0, 8'd0};
        send_area();
        // an equal id does not replace the best one: offset 2
        write_tag(8'd1);
        area_bytes = {8'd0, 8'd0, 8'd0, 8'd1, 8'h7F};
        send_area();

        // ---- random ----
        short_items = 0;
        area_count  = 0;
        while (short_items < SHORT_ITEMS) begin
            if (area_count % PHASE_AREAS == 0) begin
                steady = ($urandom_range(0, 3) == 0);
                case ($urandom_range(0, 4))
                    0: write_tag(8'd0);
                    1: write_tag(8'd255);
                    2: drain_results();   // pause only, tag kept
                    default: write_tag(8'($urandom_range(0, 255)));
                endcase
            end
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                build_walk($urandom_range(1, 48),
                           ($urandom_range(0, 9) == 0) ? 255 : 12, 1'b0);
            end else if (kind < 85) begin
                // well-formed walk with up to three of its final bytes cut off
                build_walk($urandom_range(3, 48), 12, 1'b0);
                drop = $urandom_range(1, (area_bytes.size() - 1 < 3) ?
                                         area_bytes.size() - 1 : 3);
                repeat (drop) void'(area_bytes.pop_back());
            end else begin
                area_bytes.delete();
                repeat ($urandom_range(1, 16))
                    area_bytes.push_back(8'($urandom_range(0, 255)));
            end
            send_area();
            short_items += area_bytes.size();
            area_count++;
        end

        steady = 1'b0;
        drain_results();
        if (fail_count == 0 && pending == 0)
            $display("tlv_tag_insert_locator_core regression: pass");
        else
            $display("tlv_tag_insert_locator_core regression: fail");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/tlvi_pkg.sv
rtl/tlvi_if.sv
rtl/tlvi_walk.sv
rtl/tlv_tag_insert_locator_core.sv
dv/tlv_tag_insert_locator_core_checker.sv
dv/tlv_tag_insert_locator_core_test.sv
